// ===== rtl/core/hftt_pkg.sv =====
package hftt_pkg;

    // Number of entries in the table.
    localparam int TABLE_ENTRIES = 16;
    localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    localparam int HEAD_W  = 64;
    localparam int TAIL_W  = 40;
    localparam int INO_W   = 16;
    localparam int TIME_W  = 32;
    localparam int COUNT_W = 32;
    localparam int SLOT_W  = 4;

    typedef enum logic [1:0] {
        REQ_LOOKUP = 2'd0,
        REQ_UPDATE = 2'd1,
        REQ_REMOVE = 2'd2,
        REQ_QUERY  = 2'd3
    } t_req_type;

    typedef enum logic [1:0] {
        ST_HIT      = 2'd0,
        ST_MISS     = 2'd1,
        ST_INSERTED = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    typedef struct packed {
        t_req_type           req_type;
        logic [HEAD_W-1:0]   name_head;
        logic [TAIL_W-1:0]   name_tail;
        logic [INO_W-1:0]    key_ino;
        logic [TIME_W-1:0]   now_time;
    } t_req;

    typedef struct packed {
        t_status             status;
        logic [INO_W-1:0]    found_ino;
        logic [COUNT_W-1:0]  count_out;
        logic [SLOT_W-1:0]   slot_out;
    } t_result;

endpackage

// ===== rtl/core/hftt_in_stage.sv =====
module hftt_in_stage import hftt_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_take,
    input  logic [1:0]          i_req_type,
    input  logic [HEAD_W-1:0]   i_name_head,
    input  logic [TAIL_W-1:0]   i_name_tail,
    input  logic [INO_W-1:0]    i_key_ino,
    input  logic [TIME_W-1:0]   i_now_time,
    output logic                o_valid,
    output t_req                o_req
);

    logic [103:0] n_name;
    logic [12:0]  ended;
    logic         r_valid;
    t_req         r_req;
    t_req         n_req;

    // Every byte after the first zero byte of the name is cleared.
    always_comb begin
        n_name   = {i_name_tail, i_name_head};
        ended[0] = 1'b0;
        for (int b = 1; b < 13; b++) begin
            ended[b] = ended[b-1] | (n_name[8*(b-1) +: 8] == 8'h00);
        end
        for (int b = 0; b < 13; b++) begin
            if (ended[b]) begin
                n_name[8*b +: 8] = 8'h00;
            end
        end
        n_req.req_type  = t_req_type'(i_req_type);
        n_req.name_head = n_name[HEAD_W-1:0];
        n_req.name_tail = n_name[HEAD_W +: TAIL_W];
        n_req.key_ino   = i_key_ino;
        n_req.now_time  = i_now_time;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_take;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_req <= n_req;
        end
    end

    assign o_valid = r_valid;
    assign o_req   = r_req;

endmodule

// ===== rtl/core/hftt_table.sv =====
module hftt_table import hftt_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_req    i_req,
    output t_result o_res
);

    localparam logic [TABLE_ENTRIES-1:0] ONE = TABLE_ENTRIES'(1);

    logic [HEAD_W-1:0]  r_head  [TABLE_ENTRIES];
    logic [TAIL_W-1:0]  r_tail  [TABLE_ENTRIES];
    logic [INO_W-1:0]   r_ino   [TABLE_ENTRIES];
    logic [COUNT_W-1:0] r_count [TABLE_ENTRIES];
    logic [TIME_W-1:0]  r_first [TABLE_ENTRIES];
    logic [TIME_W-1:0]  r_last  [TABLE_ENTRIES];

    logic [TABLE_ENTRIES-1:0] live, name_hit, ino_hit, rm_hit;
    logic [TABLE_ENTRIES-1:0] name_first, ino_first, rm_first, free_first;
    logic [TABLE_ENTRIES-1:0] sel, bump, ins, clr;
    logic [IDX_W-1:0]         sel_idx;
    logic [INO_W-1:0]         sel_ino;
    logic [COUNT_W-1:0]       sel_count, inc_count;

    always_comb begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            live[i]     = (r_count[i] != '0);
            name_hit[i] = live[i] && (r_head[i] == i_req.name_head)
                          && (r_tail[i] == i_req.name_tail);
            ino_hit[i]  = live[i] && (r_ino[i] == i_req.key_ino);
            rm_hit[i]   = name_hit[i] | ino_hit[i];
        end
        // Lowest set bit of each match vector.
        name_first = name_hit & (~name_hit + ONE);
        ino_first  = ino_hit & (~ino_hit + ONE);
        rm_first   = rm_hit & (~rm_hit + ONE);
        free_first = ~live & (live + ONE);

        case (i_req.req_type)
            REQ_LOOKUP: sel = name_first;
            REQ_UPDATE: sel = (|name_hit) ? name_first : free_first;
            REQ_REMOVE: sel = rm_first;
            default:    sel = ino_first;
        endcase

        sel_idx   = '0;
        sel_ino   = '0;
        sel_count = '0;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (sel[i]) begin
                sel_idx   = sel_idx | IDX_W'(i);
                sel_ino   = sel_ino | r_ino[i];
                sel_count = sel_count | r_count[i];
            end
        end
        inc_count = (sel_count == '1) ? sel_count : sel_count + COUNT_W'(1);

        bump = '0;
        ins  = '0;
        clr  = '0;
        if (i_valid) begin
            case (i_req.req_type)
                REQ_LOOKUP: bump = name_first;
                REQ_UPDATE: begin
                    bump = name_first;
                    ins  = (|name_hit) ? '0 : free_first;
                end
                REQ_REMOVE: clr = rm_hit;
                default:    ;
            endcase
        end

        o_res.status    = ST_MISS;
        o_res.found_ino = '0;
        o_res.count_out = '0;
        o_res.slot_out  = '0;
        case (i_req.req_type)
            REQ_LOOKUP: begin
                if (|name_hit) begin
                    o_res.status    = ST_HIT;
                    o_res.found_ino = sel_ino;
                    o_res.count_out = inc_count;
                    o_res.slot_out  = SLOT_W'(sel_idx);
                end
            end
            REQ_UPDATE: begin
                if (|name_hit) begin
                    o_res.status    = ST_HIT;
                    o_res.count_out = inc_count;
                    o_res.slot_out  = SLOT_W'(sel_idx);
                end else if (|free_first) begin
                    o_res.status    = ST_INSERTED;
                    o_res.count_out = COUNT_W'(1);
                    o_res.slot_out  = SLOT_W'(sel_idx);
                end else begin
                    o_res.status = ST_FULL;
                end
            end
            REQ_REMOVE: begin
                if (|rm_hit) begin
                    o_res.status   = ST_HIT;
                    o_res.slot_out = SLOT_W'(sel_idx);
                end
            end
            default: begin
                if (|ino_hit) begin
                    o_res.status    = ST_HIT;
                    o_res.count_out = sel_count;
                    o_res.slot_out  = SLOT_W'(sel_idx);
                end
            end
        endcase
    end

    // The count alone decides whether an entry is live, so only it is reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                r_count[i] <= '0;
            end
        end else begin
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                if (clr[i]) begin
                    r_count[i] <= '0;
                end else if (ins[i]) begin
                    r_count[i] <= COUNT_W'(1);
                end else if (bump[i]) begin
                    r_count[i] <= inc_count;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (clr[i]) begin
                r_head[i]  <= '0;
                r_tail[i]  <= '0;
                r_ino[i]   <= '0;
                r_first[i] <= '0;
                r_last[i]  <= '0;
            end else if (ins[i]) begin
                r_head[i]  <= i_req.name_head;
                r_tail[i]  <= i_req.name_tail;
                r_ino[i]   <= i_req.key_ino;
                r_first[i] <= i_req.now_time;
                r_last[i]  <= i_req.now_time;
            end else if (bump[i]) begin
                r_last[i]  <= i_req.now_time;
            end
        end
    end

endmodule

// ===== rtl/core/hot_file_tag_table_top.sv =====
// Channel   Handshake          Width   Beat carries
// request   start / busy       154     i_req_type, i_name_head, i_name_tail,
//                                      i_key_ino, i_now_time
// result    o_valid (strobe)   54      o_status, o_found_ino, o_count_out, o_slot_out
//
// A request is taken on every clock edge at which start is high; busy is never raised.
// Its result passes through the input register and then the result register, into which
// the associative compare, priority pick and entry update settle.
// The table update lands on the same edge as the result, so back-to-back requests see it.
// Reset is synchronous and active low; it empties the table and clears both strobes.
// The receiver cannot stall: every result beat is shown for one cycle only.
module hot_file_tag_table_top import hftt_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          i_req_type,
    input  logic [HEAD_W-1:0]   i_name_head,
    input  logic [TAIL_W-1:0]   i_name_tail,
    input  logic [INO_W-1:0]    i_key_ino,
    input  logic [TIME_W-1:0]   i_now_time,
    output logic                o_valid,
    output logic [1:0]          o_status,
    output logic [INO_W-1:0]    o_found_ino,
    output logic [COUNT_W-1:0]  o_count_out,
    output logic [SLOT_W-1:0]   o_slot_out
);

    logic    req_valid;
    t_req    req;
    t_result res;
    logic    r_valid;
    t_result r_res;

    // No stage ever stalls, so the block never refuses a beat.
    assign busy = 1'b0;

    // Input register; the name is normalised on its way in.
    hftt_in_stage u_in_stage (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (start),
        .i_req_type  (i_req_type),
        .i_name_head (i_name_head),
        .i_name_tail (i_name_tail),
        .i_key_ino   (i_key_ino),
        .i_now_time  (i_now_time),
        .o_valid     (req_valid),
        .o_req       (req)
    );

    // Entry store with parallel compares; it updates itself when req_valid is high.
    hftt_table u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (req_valid),
        .i_req   (req),
        .o_res   (res)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= req_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_valid) begin
            r_res <= res;
        end
    end

    assign o_valid     = r_valid;
    assign o_status    = r_res.status;
    assign o_found_ino = r_res.found_ino;
    assign o_count_out = r_res.count_out;
    assign o_slot_out  = r_res.slot_out;

`ifndef SYNTHESIS
    // Every accepted request yields its result after the input and result registers.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##2 o_valid)
        else $error("request without result");

    // No result beat without a request taken earlier.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, 2))
        else $error("result without request");

    // A full table reports nothing else.
    a_full_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_FULL) |->
            (o_slot_out == '0 && o_count_out == '0 && o_found_ino == '0))
        else $error("full status with non-zero fields");

    // An inode is only returned on a hit.
    a_ino_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_found_ino != '0) |-> (o_status == ST_HIT))
        else $error("inode returned without a hit");
`endif

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import hftt_pkg::*;

    // The table keeps a 13-byte name, which is carried here as one 104-bit word:
    // the head in the low 64 bits and the tail above it, first character lowest.
    localparam int NAME_W = HEAD_W + TAIL_W;

    // Names and inodes that the random part draws from, so that lookups hit,
    // the table fills up and removals find something to clear.
    localparam int POOL_SIZE = 20;

    // Roughly 950 random beats, spread over four pacing phases.
    localparam int BEATS_PER_PHASE = 238;

    // Chance, in percent, that the sender idles on a given cycle in each phase.
    // The receiver cannot hold results off, so the third phase, which would have
    // stalled the receiver, simply runs flat out like the first one.
    localparam int IDLE_PCT [4] = '{0, 54, 0, 35};

    // Clock and reset. Every input of the block is driven to a known value from
    // time zero, and reset is held low until it is released on a falling edge.
    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               start       = 1'b0;
    logic [1:0]         i_req_type  = '0;
    logic [HEAD_W-1:0]  i_name_head = '0;
    logic [TAIL_W-1:0]  i_name_tail = '0;
    logic [INO_W-1:0]   i_key_ino   = '0;
    logic [TIME_W-1:0]  i_now_time  = '0;

    logic               busy;
    logic               o_valid;
    logic [1:0]         o_status;
    logic [INO_W-1:0]   o_found_ino;
    logic [COUNT_W-1:0] o_count_out;
    logic [SLOT_W-1:0]  o_slot_out;

    always #5 i_clk = ~i_clk;

    hot_file_tag_table_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req_type  (i_req_type),
        .i_name_head (i_name_head),
        .i_name_tail (i_name_tail),
        .i_key_ino   (i_key_ino),
        .i_now_time  (i_now_time),
        .o_valid     (o_valid),
        .o_status    (o_status),
        .o_found_ino (o_found_ino),
        .o_count_out (o_count_out),
        .o_slot_out  (o_slot_out)
    );

    // Our own copy of the table, kept in step with every accepted request.
    logic [NAME_W-1:0]  tbl_name  [TABLE_ENTRIES];
    logic [INO_W-1:0]   tbl_ino   [TABLE_ENTRIES];
    logic [COUNT_W-1:0] tbl_count [TABLE_ENTRIES];
    logic [TIME_W-1:0]  tbl_first [TABLE_ENTRIES];
    logic [TIME_W-1:0]  tbl_last  [TABLE_ENTRIES];

    // Results that have been worked out for accepted requests but not yet seen.
    t_result pending_results [$];
    int      mismatch_count = 0;

    // Sender pacing for the current phase.
    int idle_pct = 0;

    // Random pool of well-formed names, their lengths and their inodes.
    logic [NAME_W-1:0] pool_name [POOL_SIZE];
    int                pool_len  [POOL_SIZE];
    logic [INO_W-1:0]  pool_ino  [POOL_SIZE];

    // One row of the directed stimulus. Where the outcome is obvious it is typed
    // in by hand; otherwise the predictor supplies it.
    typedef struct {
        t_req    req;
        bit      typed;
        t_result res;
    } t_row;

    t_row plan [$];

    // A name ends at its first zero byte; anything after it is junk and must be
    // cleared before the name is compared or stored.
    function automatic logic [NAME_W-1:0] clean_name(input logic [HEAD_W-1:0] head,
                                                     input logic [TAIL_W-1:0] tail);
        logic [NAME_W-1:0] nm;
        bit                ended;
        int                p;
        nm    = {tail, head};
        ended = 1'b0;
        for (p = 0; p < 13; p++) begin
            if (ended) begin
                nm[p*8 +: 8] = 8'h00;
            end else if (nm[p*8 +: 8] == 8'h00) begin
                ended = 1'b1;
            end
        end
        return nm;
    endfunction

    // Works out the result of one request and applies its effect to our copy of
    // the table. Every search takes the lowest matching slot, and an entry only
    // counts as live while its access count is above zero.
    task automatic predict_access(input t_req r, output t_result res);
        logic [NAME_W-1:0] key;
        int                hit;
        int                i;
        key           = clean_name(r.name_head, r.name_tail);
        hit           = -1;
        res.status    = ST_MISS;
        res.found_ino = '0;
        res.count_out = '0;
        res.slot_out  = '0;
        case (r.req_type)
            REQ_LOOKUP, REQ_UPDATE: begin
                for (i = 0; i < TABLE_ENTRIES; i++) begin
                    if (hit < 0 && tbl_count[i] != '0 && tbl_name[i] == key) hit = i;
                end
                if (hit >= 0) begin
                    // The count sticks at its maximum rather than wrapping.
                    if (tbl_count[hit] != '1) tbl_count[hit] = tbl_count[hit] + 1'b1;
                    tbl_last[hit] = r.now_time;
                    res.status    = ST_HIT;
                    res.count_out = tbl_count[hit];
                    res.slot_out  = hit[SLOT_W-1:0];
                    if (r.req_type == REQ_LOOKUP) res.found_ino = tbl_ino[hit];
                end else if (r.req_type == REQ_UPDATE) begin
                    for (i = 0; i < TABLE_ENTRIES; i++) begin
                        if (hit < 0 && tbl_count[i] == '0) hit = i;
                    end
                    if (hit >= 0) begin
                        tbl_name[hit]  = key;
                        tbl_ino[hit]   = r.key_ino;
                        tbl_count[hit] = 1;
                        tbl_first[hit] = r.now_time;
                        tbl_last[hit]  = r.now_time;
                        res.status     = ST_INSERTED;
                        res.count_out  = 1;
                        res.slot_out   = hit[SLOT_W-1:0];
                    end else begin
                        res.status = ST_FULL;
                    end
                end
            end
            REQ_REMOVE: begin
                // Every live entry matching by name or by inode goes at once.
                for (i = 0; i < TABLE_ENTRIES; i++) begin
                    if (tbl_count[i] != '0 && (tbl_name[i] == key || tbl_ino[i] == r.key_ino)) begin
                        if (hit < 0) hit = i;
                        tbl_name[i]  = '0;
                        tbl_ino[i]   = '0;
                        tbl_count[i] = '0;
                        tbl_first[i] = '0;
                        tbl_last[i]  = '0;
                    end
                end
                if (hit >= 0) begin
                    res.status   = ST_HIT;
                    res.slot_out = hit[SLOT_W-1:0];
                end
            end
            default: begin
                for (i = 0; i < TABLE_ENTRIES; i++) begin
                    if (hit < 0 && tbl_count[i] != '0 && tbl_ino[i] == r.key_ino) hit = i;
                end
                if (hit >= 0) begin
                    res.status    = ST_HIT;
                    res.count_out = tbl_count[hit];
                    res.slot_out  = hit[SLOT_W-1:0];
                end
            end
        endcase
    endtask

    task automatic add_row(input t_req_type op, input logic [HEAD_W-1:0] head,
                           input logic [TAIL_W-1:0] tail, input logic [INO_W-1:0] ino,
                           input logic [TIME_W-1:0] now, input bit typed, input t_status st,
                           input logic [INO_W-1:0] found, input logic [COUNT_W-1:0] cnt,
                           input logic [SLOT_W-1:0] slot);
        t_row row;
        row.req.req_type  = op;
        row.req.name_head = head;
        row.req.name_tail = tail;
        row.req.key_ino   = ino;
        row.req.now_time  = now;
        row.typed         = typed;
        row.res.status    = st;
        row.res.found_ino = found;
        row.res.count_out = cnt;
        row.res.slot_out  = slot;
        plan.push_back(row);
    endtask

    // Mostly well-formed traffic on the pool names, with a share of junk after
    // the terminator and a share of fully random names and inodes as noise.
    function automatic t_req make_random_req();
        t_req                  r;
        int                    k;
        int                    b;
        int                    pick;
        logic [127:0]          raw;
        logic [NAME_W-1:0]     nm;
        pick = $urandom_range(99);
        if (pick < 30) begin
            r.req_type = REQ_LOOKUP;
        end else if (pick < 65) begin
            r.req_type = REQ_UPDATE;
        end else if (pick < 80) begin
            r.req_type = REQ_REMOVE;
        end else begin
            r.req_type = REQ_QUERY;
        end
        k    = $urandom_range(POOL_SIZE - 1);
        pick = $urandom_range(99);
        if (pick < 15) begin
            raw = {$urandom, $urandom, $urandom, $urandom};
            nm  = raw[NAME_W-1:0];
        end else begin
            nm = pool_name[k];
            if (pick < 40) begin
                for (b = pool_len[k] + 1; b < 13; b++) nm[b*8 +: 8] = 8'($urandom);
            end
        end
        pick = $urandom_range(99);
        if (r.req_type == REQ_UPDATE && pick < 80) begin
            r.key_ino = pool_ino[k];
        end else if (pick < 70) begin
            r.key_ino = pool_ino[$urandom_range(POOL_SIZE - 1)];
        end else begin
            r.key_ino = 16'($urandom);
        end
        r.name_head = nm[HEAD_W-1:0];
        r.name_tail = nm[NAME_W-1:HEAD_W];
        r.now_time  = $urandom;
        return r;
    endfunction

    // Presents one request beat. Inputs only change on the falling edge, and
    // start is assigned exactly once per falling edge, so a request that follows
    // straight on keeps start high without a glitch. While idle the payload
    // carries junk, which the block must ignore.
    task automatic drive_beat(input t_req r, input bit typed, input t_result typed_res);
        t_result pred;
        @(negedge i_clk);
        while ($urandom_range(99) < idle_pct) begin
            start       <= 1'b0;
            i_req_type  <= 2'($urandom);
            i_name_head <= {$urandom, $urandom};
            i_name_tail <= 40'({$urandom, $urandom});
            i_key_ino   <= 16'($urandom);
            i_now_time  <= $urandom;
            @(negedge i_clk);
        end
        start       <= 1'b1;
        i_req_type  <= r.req_type;
        i_name_head <= r.name_head;
        i_name_tail <= r.name_tail;
        i_key_ino   <= r.key_ino;
        i_now_time  <= r.now_time;
        do @(posedge i_clk); while (busy !== 1'b0);
        // Accepted on this edge: the table changes in request order, so the
        // prediction is made right here.
        predict_access(r, pred);
        pending_results.push_back(typed ? typed_res : pred);
    endtask

    // Holds the sender off until every outstanding result has come back.
    task automatic pause_for_results();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Result checker: each strobed beat is matched against the oldest pending
    // expectation, field by field.
    always @(posedge i_clk) begin : result_check
        t_result got;
        t_result want;
        if (i_rst_n === 1'b1 && o_valid === 1'b1) begin
            got.status    = t_status'(o_status);
            got.found_ino = o_found_ino;
            got.count_out = o_count_out;
            got.slot_out  = o_slot_out;
            if (pending_results.size() == 0) begin
                if (mismatch_count < 10) begin
                    $display("Unexpected result beat at %0t: status %0d ino %h count %h slot %0d",
                             $realtime, o_status, o_found_ino, o_count_out, o_slot_out);
                end
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    if (mismatch_count < 10) begin
                        $display("Mismatch at %0t: got status %0d ino %h count %h slot %0d",
                                 $realtime, o_status, o_found_ino, o_count_out, o_slot_out);
                        $display("          expected status %0d ino %h count %h slot %0d",
                                 want.status, want.found_ino, want.count_out, want.slot_out);
                    end
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        int      k;
        int      b;
        int      ph;
        int      n;
        t_result no_typed;
        no_typed = '0;

        for (k = 0; k < TABLE_ENTRIES; k++) begin
            tbl_name[k]  = '0;
            tbl_ino[k]   = '0;
            tbl_count[k] = '0;
            tbl_first[k] = '0;
            tbl_last[k]  = '0;
        end

        // Pool names run from empty to the full 13 characters, with no zero
        // byte inside them. Half the inodes are small so that several entries
        // share one and a removal by inode clears more than one slot.
        for (k = 0; k < POOL_SIZE; k++) begin
            pool_len[k]  = $urandom_range(13);
            pool_name[k] = '0;
            for (b = 0; b < pool_len[k]; b++) pool_name[k][b*8 +: 8] = 8'($urandom_range(255, 1));
            pool_ino[k]  = (k % 2 == 1) ? 16'($urandom) : 16'($urandom_range(7));
        end

        // Directed part. An empty table misses on lookup, query and removal, then
        // extreme names, inodes and times, a name with junk after its
        // terminator, an empty name, an update that bumps, a full table, a
        // removal that clears two entries at once, and reuse of a freed slot.
        // Saturation of the count cannot be reached from the ports in any
        // sensible run length, so it is left to the predictor alone.
        add_row(REQ_LOOKUP, 64'h0000_0000_0000_0061, '0, '0, '0,
                1'b1, ST_MISS, '0, '0, '0);
        add_row(REQ_QUERY, '0, '0, '0, '0, 1'b1, ST_MISS, '0, '0, '0);
        add_row(REQ_REMOVE, '0, '0, '0, '0, 1'b1, ST_MISS, '0, '0, '0);
        add_row(REQ_UPDATE, '1, '1, '1, '1, 1'b1, ST_INSERTED, '0, 32'd1, 4'd0);
        add_row(REQ_LOOKUP, '1, '1, '0, 32'd7, 1'b1, ST_HIT, 16'hFFFF, 32'd2, 4'd0);
        add_row(REQ_QUERY, '0, '0, 16'hFFFF, '0, 1'b1, ST_HIT, '0, 32'd2, 4'd0);
        // "ab" followed by a terminator and junk in both words.
        add_row(REQ_UPDATE, 64'hDEBE_EFC0_FF00_6261, 40'hFF_FFFF_FFFF, 16'h1234, '0,
                1'b1, ST_INSERTED, '0, 32'd1, 4'd1);
        add_row(REQ_LOOKUP, 64'h0000_0000_0000_6261, '0, '0, 32'd1,
                1'b1, ST_HIT, 16'h1234, 32'd2, 4'd1);
        // Empty name: a zero first byte wipes the whole key.
        add_row(REQ_UPDATE, '0, 40'hA5_A5A5_A5A5, '0, 32'd5, 1'b1, ST_INSERTED, '0, 32'd1, 4'd2);
        add_row(REQ_UPDATE, '1, '1, '0, 32'd9, 1'b1, ST_HIT, '0, 32'd3, 4'd0);
        for (k = 0; k < 13; k++) begin
            add_row(REQ_UPDATE, 64'(8'h41 + k), '0, 16'(16'h0100 + k), 32'(k),
                    1'b1, ST_INSERTED, '0, 32'd1, 4'(3 + k));
        end
        add_row(REQ_UPDATE, 64'h0000_0000_0000_005A, '0, 16'h0BAD, '0,
                1'b1, ST_FULL, '0, '0, '0);
        // Matches "ab" by name and the sixth single-letter entry by inode.
        add_row(REQ_REMOVE, 64'h0000_0000_0000_6261, '0, 16'h0105, '0,
                1'b1, ST_HIT, '0, '0, 4'd1);
        add_row(REQ_UPDATE, 64'h0000_0000_0000_005A, '0, 16'h0BAD, 32'd11,
                1'b0, ST_MISS, '0, '0, '0);
        add_row(REQ_LOOKUP, '0, '0, '0, 32'd12, 1'b0, ST_MISS, '0, '0, '0);

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        idle_pct = 25;
        foreach (plan[n]) drive_beat(plan[n].req, plan[n].typed, plan[n].res);
        pause_for_results();

        // Random part, one pacing phase after another. Now and then, and at the
        // end of each phase, the sender waits for the pipeline to empty.
        for (ph = 0; ph < 4; ph++) begin
            idle_pct = IDLE_PCT[ph];
            for (n = 0; n < BEATS_PER_PHASE; n++) begin
                if ($urandom_range(59) == 0) pause_for_results();
                drive_beat(make_random_req(), 1'b0, no_typed);
            end
            pause_for_results();
        end

        // A few more cycles to catch any stray beat after the last result.
        repeat (4) @(posedge i_clk);

        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Watchdog: far longer than the slowest correct run needs.
    initial begin
        #1_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

// ===== hot_file_tag_table_top.f =====
rtl/core/hftt_pkg.sv
rtl/core/hftt_in_stage.sv
rtl/core/hftt_table.sv
rtl/core/hot_file_tag_table_top.sv
tb/tb.sv
